/* rtl/proportional_glyph_renderer_macros.svh */
// Assertion macros for the glyph renderer RTL.
// Used by proportional_glyph_renderer.sv; expects i_clk and i_rst_n in scope.
`ifndef PROPORTIONAL_GLYPH_RENDERER_MACROS_SVH
`define PROPORTIONAL_GLYPH_RENDERER_MACROS_SVH

// same-cycle implication, masked during reset
`define PGR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pgr: same-cycle check failed");

// next-cycle implication, masked during reset
`define PGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pgr: next-cycle check failed");

`endif

/* rtl/pgr_pkg.sv */
// Shared types, constants and helpers for the glyph renderer.
// No dependencies; imported by the top level.
package pgr_pkg;

    localparam int unsigned FONT_DEPTH_DEF = 65536;
    localparam int unsigned MAX_SIDE       = 16;
    localparam int unsigned NUM_BANKS      = 16;
    localparam int unsigned BANK_SEL_W     = 4;
    localparam int unsigned CFG_W          = 17;
    localparam int unsigned CFG_IDX_W      = 3;

    localparam logic [7:0] CODE_FIRST = 8'd33;
    localparam logic [7:0] INV_REF    = 8'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_SPACING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_LENGTH  = 3'd5;

    // command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_CURSOR = 2'd1;
    localparam logic [1:0] CMD_DRAW   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ISSUE,
        S_CAPTURE,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        font_address;
        logic [7:0]         font_byte;
        logic [7:0]         char_code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               invert;
    } t_in;

    typedef struct packed {
        logic signed [15:0] row_x;
        logic signed [15:0] row_y;
        logic [15:0]        opaque_mask;
        logic [63:0]        colors_low;
        logic [63:0]        colors_high;
        logic signed [15:0] next_x;
        logic               last;
    } t_out;

    // zero acts as one, oversize acts as the largest side
    function automatic logic [4:0] clamp_side(input logic [4:0] v);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (v > 5'(MAX_SIDE)) begin
            r = 5'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/pgr_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pgr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/proportional_glyph_renderer.sv */
// Proportional glyph renderer: top level. Uses pgr_pkg, pgr_ram and the macro header.
// Draws glyphs from a byte-per-pixel font held in sixteen interleaved RAM banks.
//
// A transaction on the input channel is one command. A font load stores one byte
// and a cursor set moves the cursor; neither gives a result. A draw of a code
// below 33 gives one empty row. A draw of a printable code takes the command,
// then does the glyph offset multiply, then issues the first row read, then gives
// one glyph row per cycle while the output side keeps up. The row rate is set by
// the font store: a glyph row of up to sixteen consecutive bytes is fetched in one
// read, since byte address a lives in bank a mod 16, so every bank delivers
// at most one pixel of the row. Output stalls hold the row pipeline. A finished row
// waits in the output register while the next command is accepted. Configuration
// writes take effect at once and are expected only while no draw is in progress.
`include "proportional_glyph_renderer_macros.svh"

module proportional_glyph_renderer
    import pgr_pkg::*;
#(
    parameter int unsigned FONT_DEPTH = FONT_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    // row result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned BANK_DEPTH = FONT_DEPTH / NUM_BANKS;
    localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state      r_state,        n_state;
    logic [4:0]  r_glyph_width,  n_glyph_width;
    logic [4:0]  r_glyph_height, n_glyph_height;
    logic [7:0]  r_base_color,   n_base_color;
    logic [7:0]  r_space_width,  n_space_width;
    logic [7:0]  r_char_spacing, n_char_spacing;
    logic [16:0] r_font_length,  n_font_length;
    logic [15:0] r_cursor_x,     n_cursor_x;
    logic [15:0] r_cursor_y,     n_cursor_y;
    logic        r_out_valid,    n_out_valid;
    t_out        r_out,          n_out;

    // draw sequencing
    logic        r_invert,       n_invert;
    logic [8:0]  r_wh,           n_wh;          // cell area
    logic [7:0]  r_code_off,     n_code_off;    // glyph number
    logic [15:0] r_next_start,   n_next_start;  // first byte of the next row to read
    logic [15:0] r_cap_start,    n_cap_start;   // first byte of the row in the banks
    logic [3:0]  r_cap_row,      n_cap_row;
    logic [3:0]  r_maxcol,       n_maxcol;

    // ------------------------------------------------------------------
    // Font banks
    // ------------------------------------------------------------------
    logic                  ram_we;
    logic                  ram_re;
    logic [31:0]           wr_full;
    logic [BANK_SEL_W-1:0] wr_bank;
    logic [BANK_AW-1:0]    wr_row;
    logic                  wr_ok;
    logic [31:0]           rd_full;
    logic [BANK_SEL_W-1:0] rd_lo;
    logic [BANK_AW-1:0]    rd_hi;
    logic [7:0]            bank_q [NUM_BANKS];

    assign wr_full = 32'(i_in.font_address);
    assign wr_bank = wr_full[BANK_SEL_W-1:0];
    assign wr_row  = wr_full[BANK_AW+BANK_SEL_W-1:BANK_SEL_W];
    assign wr_ok   = wr_full < 32'(FONT_DEPTH);

    assign rd_full = 32'(r_next_start);
    assign rd_lo   = rd_full[BANK_SEL_W-1:0];
    assign rd_hi   = rd_full[BANK_AW+BANK_SEL_W-1:BANK_SEL_W];

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [BANK_AW-1:0] raddr;
        // banks below the row's start offset hold bytes of the following line
        assign raddr = rd_hi + ((BANK_SEL_W'(b) < rd_lo) ? BANK_AW'(1) : BANK_AW'(0));

        pgr_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (ram_we && (wr_bank == BANK_SEL_W'(b))),
            .i_waddr (wr_row),
            .i_wdata (i_in.font_byte),
            .i_re    (ram_re),
            .i_raddr (raddr),
            .o_rdata (bank_q[b])
        );
    end

    // ------------------------------------------------------------------
    // Row decode: rotate bank data into column order, mark opaque pixels
    // ------------------------------------------------------------------
    logic [4:0]  w_c;
    logic [4:0]  h_c;
    logic [15:0] row_mask;
    logic [7:0]  row_color [NUM_BANKS];
    logic [63:0] row_lo;
    logic [63:0] row_hi;
    logic [3:0]  row_max;
    logic [3:0]  cur_max;
    logic [15:0] glyph_next_x;
    logic [15:0] space_next_x;
    logic        last_row;
    logic        out_free;

    assign w_c = clamp_side(r_glyph_width);
    assign h_c = clamp_side(r_glyph_height);

    always_comb begin
        logic [BANK_SEL_W-1:0] sel;
        logic [7:0]            v;
        logic [7:0]            vm;
        logic [16:0]           idx;
        logic                  in_len;
        logic                  in_mem;
        for (int c = 0; c < NUM_BANKS; c++) begin
            sel    = r_cap_start[BANK_SEL_W-1:0] + BANK_SEL_W'(c);
            v      = bank_q[sel];
            idx    = 17'(r_cap_start) + 17'(c);
            // a byte only counts when its index plus one is below the loaded length
            in_len = (18'(idx) + 18'd1) < 18'(r_font_length);
            in_mem = 32'(idx) < 32'(FONT_DEPTH);
            vm     = r_invert ? (INV_REF - v) : v;
            row_mask[c]  = (5'(c) < w_c) && in_len && in_mem && (v != 8'd0);
            row_color[c] = row_mask[c] ? (vm + r_base_color - 8'd1) : 8'd0;
        end
    end

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            row_lo[8*c +: 8] = row_color[c];
            row_hi[8*c +: 8] = row_color[c+8];
        end
    end

    // rightmost opaque column of this row
    always_comb begin
        row_max = 4'd0;
        for (int c = 0; c < NUM_BANKS; c++) begin
            if (row_mask[c]) begin
                row_max = 4'(c);
            end
        end
    end

    assign cur_max      = (row_max > r_maxcol) ? row_max : r_maxcol;
    assign glyph_next_x = r_cursor_x + 16'(cur_max) + 16'(r_char_spacing);
    assign space_next_x = r_cursor_x + 16'(r_space_width);
    assign last_row     = {1'b0, r_cap_row} == (h_c - 5'd1);
    assign out_free     = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_glyph_width  = r_glyph_width;
        n_glyph_height = r_glyph_height;
        n_base_color   = r_base_color;
        n_space_width  = r_space_width;
        n_char_spacing = r_char_spacing;
        n_font_length  = r_font_length;
        n_cursor_x     = r_cursor_x;
        n_cursor_y     = r_cursor_y;
        n_out_valid    = r_out_valid;
        n_out          = r_out;
        n_invert       = r_invert;
        n_wh           = r_wh;
        n_code_off     = r_code_off;
        n_next_start   = r_next_start;
        n_cap_start    = r_cap_start;
        n_cap_row      = r_cap_row;
        n_maxcol       = r_maxcol;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        o_in_ready     = (r_state == S_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GLYPH_WIDTH:  n_glyph_width  = i_cfg_data[4:0];
                CFG_GLYPH_HEIGHT: n_glyph_height = i_cfg_data[4:0];
                CFG_BASE_COLOR:   n_base_color   = i_cfg_data[7:0];
                CFG_SPACE_WIDTH:  n_space_width  = i_cfg_data[7:0];
                CFG_CHAR_SPACING: n_char_spacing = i_cfg_data[7:0];
                CFG_FONT_LENGTH:  n_font_length  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.command)
                        CMD_LOAD: begin
                            ram_we = wr_ok;
                        end
                        CMD_CURSOR: begin
                            n_cursor_x = i_in.pos_x;
                            n_cursor_y = i_in.pos_y;
                        end
                        CMD_DRAW: begin
                            n_invert = i_in.invert;
                            if (i_in.char_code < CODE_FIRST) begin
                                n_state = S_EMPTY;
                            end else begin
                                n_wh       = 9'(w_c * h_c);
                                n_code_off = i_in.char_code - CODE_FIRST;
                                n_maxcol   = 4'd0;
                                n_state    = S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                // glyph offset stays below 2^16 for any cell size and code
                n_next_start = 16'(r_wh * r_code_off);
                n_state      = S_ISSUE;
            end
            S_ISSUE: begin
                ram_re       = 1'b1;
                n_cap_start  = r_next_start;
                n_next_start = r_next_start + 16'(w_c);
                n_cap_row    = 4'd0;
                n_state      = S_CAPTURE;
            end
            S_CAPTURE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.row_x       = r_cursor_x;
                    n_out.row_y       = r_cursor_y + 16'(r_cap_row);
                    n_out.opaque_mask = row_mask;
                    n_out.colors_low  = row_lo;
                    n_out.colors_high = row_hi;
                    n_maxcol          = cur_max;
                    if (last_row) begin
                        n_out.next_x = glyph_next_x;
                        n_out.last   = 1'b1;
                        n_cursor_x   = glyph_next_x;
                        n_state      = S_IDLE;
                    end else begin
                        // overlap: fetch the next row while this one is handed out
                        n_out.next_x = 16'd0;
                        n_out.last   = 1'b0;
                        ram_re       = 1'b1;
                        n_cap_start  = r_next_start;
                        n_next_start = r_next_start + 16'(w_c);
                        n_cap_row    = r_cap_row + 4'd1;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.row_x       = r_cursor_x;
                    n_out.row_y       = r_cursor_y;
                    n_out.opaque_mask = 16'd0;
                    n_out.colors_low  = 64'd0;
                    n_out.colors_high = 64'd0;
                    n_out.next_x      = space_next_x;
                    n_out.last        = 1'b1;
                    n_cursor_x        = space_next_x;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_glyph_width  <= 5'd8;
            r_glyph_height <= 5'd9;
            r_base_color   <= 8'd134;
            r_space_width  <= 8'd5;
            r_char_spacing <= 8'd0;
            r_font_length  <= 17'd0;
            r_cursor_x     <= 16'd0;
            r_cursor_y     <= 16'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_glyph_width  <= n_glyph_width;
            r_glyph_height <= n_glyph_height;
            r_base_color   <= n_base_color;
            r_space_width  <= n_space_width;
            r_char_spacing <= n_char_spacing;
            r_font_length  <= n_font_length;
            r_cursor_x     <= n_cursor_x;
            r_cursor_y     <= n_cursor_y;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload and sequencing data, no reset needed
    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_invert     <= n_invert;
        r_wh         <= n_wh;
        r_code_off   <= n_code_off;
        r_next_start <= n_next_start;
        r_cap_start  <= n_cap_start;
        r_cap_row    <= n_cap_row;
        r_maxcol     <= n_maxcol;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PGR_ASSERT_IMPL(a_write_only_idle, ram_we, r_state == S_IDLE)
    `PGR_ASSERT_IMPL(a_read_only_draw, ram_re, r_state == S_ISSUE || r_state == S_CAPTURE)
    `PGR_ASSERT_IMPL(a_row_in_cell, r_state == S_CAPTURE, {1'b0, r_cap_row} < h_c)
    `PGR_ASSERT_NEXT(a_last_moves_cursor, r_state == S_CAPTURE && out_free && last_row, r_state == S_IDLE && r_out_valid && r_out.last && r_cursor_x == r_out.next_x)

endmodule
